// ===== src/grouped_fifo_team_queue_assert.svh =====
// Assertion shorthands used by the checker of this block.
`ifndef GROUPED_FIFO_TEAM_QUEUE_ASSERT_SVH
`define GROUPED_FIFO_TEAM_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GFTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GFTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gftq_pkg.sv =====
`default_nettype none
package gftq_pkg;

   localparam int ELEMENT_W = 16;
   localparam int TEAM_ID_W = 10;
   localparam int PRED_W    = 11;

   typedef enum logic [1:0] {
      OP_ASSIGN  = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_POOL_FULL = 2'd2,
      ST_TEAMS_OUT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_ENQ_LOOK,
      S_ENQ_LINK,
      S_DEQ_TEAM,
      S_DEQ_NODE,
      S_DEQ_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [ELEMENT_W-1:0] element;
      logic [TEAM_ID_W-1:0] team_id;
   } req_type;

   typedef struct packed {
      logic [ELEMENT_W-1:0] element_out;
      logic                 has_element;
      logic [1:0]           status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/gftq_ram.sv =====
`default_nettype none
module gftq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== src/grouped_fifo_team_queue.sv =====
// Channel  | Ports                            | Flow
// ---------+----------------------------------+------------------------------
// request  | start, busy, req_data            | taken when start & !busy
// response | rsp_valid, rsp_data              | one-cycle strobe, no stall
// csr      | csr_we, csr_wdata                | predefined team count
//
// Assign, no-op and a dequeue of an empty line respond from the dispatch state;
// an enqueue passes through look and link states (an error answers from look),
// a dequeue through team, node and finish states: each op walks its chain of
// dependent reads through the registered membership, team, node, free and ring RAMs.
// After reset a clearing pass wipes membership and team state and refills the free
// list; busy stays high meanwhile. Responses cannot be stalled.
`default_nettype none
module grouped_fifo_team_queue
   import gftq_pkg::*;
#(
   parameter int ELEMENTS = 65536,
   parameter int TEAMS    = 1024,
   parameter int CAPACITY = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [PRED_W-1:0] csr_wdata
);

   localparam int EW   = $clog2(ELEMENTS);
   localparam int TW   = $clog2(TEAMS);
   localparam int CW   = $clog2(CAPACITY);
   localparam int MW   = TW + 1;
   localparam int NW   = (TW + 1 > PRED_W) ? TW + 1 : PRED_W;
   localparam int CLR0 = (ELEMENTS > TEAMS) ? ELEMENTS : TEAMS;
   localparam int CLR  = (CLR0 > CAPACITY) ? CLR0 : CAPACITY;
   localparam int CLRW = $clog2(CLR) + 1;
   localparam int TMW  = 2 * CW + 1;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CLRW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [TW-1:0]    oh_ff, oh_in;
   logic [TW:0]      oc_ff, oc_in;
   logic [CW:0]      fc_ff, fc_in;
   logic [NW-1:0]    nft_ff, nft_in;
   logic [TW-1:0]    team_ff, team_in;
   logic [CW-1:0]    node_ff, node_in;
   logic [CW-1:0]    head_ff, head_in;
   logic [CW-1:0]    tail_ff, tail_in;

   logic             mem_we;
   logic [EW-1:0]    mem_wa, mem_ra;
   logic [MW-1:0]    mem_wd, mem_rd;
   logic             team_we;
   logic [TW-1:0]    team_wa, team_ra;
   logic [TMW-1:0]   team_wd, team_rd;
   logic             val_we;
   logic [CW-1:0]    val_wa, val_ra;
   logic [ELEMENT_W-1:0] val_wd, val_rd;
   logic             nxt_we;
   logic [CW-1:0]    nxt_wa, nxt_ra;
   logic [CW-1:0]    nxt_wd, nxt_rd;
   logic             free_we;
   logic [CW-1:0]    free_wa, free_ra;
   logic [CW-1:0]    free_wd, free_rd;
   logic             ring_we;
   logic [TW-1:0]    ring_wa, ring_ra;
   logic [TW-1:0]    ring_wd, ring_rd;

   logic [EW-1:0]    slot;
   logic [TW-1:0]    assign_team;
   logic [NW:0]      cand;
   logic             ids_out;
   logic [TW-1:0]    look_team;
   logic             rd_in_line;
   logic [CW-1:0]    rd_head, rd_tail;

   assign slot        = EW'({{EW{1'b0}}, req_ff.element});
   assign assign_team = TW'({{TW{1'b0}}, req_ff.team_id});
   assign cand        = {1'b0, nft_ff} + 1'b1;
   assign ids_out     = cand >= (NW + 1)'(TEAMS);
   assign look_team   = (mem_rd == '0) ? TW'(cand) : TW'(mem_rd - 1'b1);
   assign rd_in_line  = team_rd[TMW-1];
   assign rd_head     = team_rd[2*CW-1:CW];
   assign rd_tail     = team_rd[CW-1:0];

   gftq_ram #(.DEPTH(ELEMENTS), .WIDTH(MW)) u_member (
      .clock(clock), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
      .raddr(mem_ra), .rdata(mem_rd));
   gftq_ram #(.DEPTH(TEAMS), .WIDTH(TMW)) u_team (
      .clock(clock), .we(team_we), .waddr(team_wa), .wdata(team_wd),
      .raddr(team_ra), .rdata(team_rd));
   gftq_ram #(.DEPTH(CAPACITY), .WIDTH(ELEMENT_W)) u_value (
      .clock(clock), .we(val_we), .waddr(val_wa), .wdata(val_wd),
      .raddr(val_ra), .rdata(val_rd));
   gftq_ram #(.DEPTH(CAPACITY), .WIDTH(CW)) u_next (
      .clock(clock), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
      .raddr(nxt_ra), .rdata(nxt_rd));
   gftq_ram #(.DEPTH(CAPACITY), .WIDTH(CW)) u_free (
      .clock(clock), .we(free_we), .waddr(free_wa), .wdata(free_wd),
      .raddr(free_ra), .rdata(free_rd));
   gftq_ram #(.DEPTH(TEAMS), .WIDTH(TW)) u_ring (
      .clock(clock), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
      .raddr(ring_ra), .rdata(ring_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         oh_ff        <= '0;
         oc_ff        <= '0;
         fc_ff        <= (CW + 1)'(CAPACITY);
         nft_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
         oh_ff        <= oh_in;
         oc_ff        <= oc_in;
         fc_ff        <= fc_in;
         nft_ff       <= nft_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      team_ff <= team_in;
      node_ff <= node_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      clr_cnt_in   = clr_cnt_ff;
      oh_in        = oh_ff;
      oc_in        = oc_ff;
      fc_in        = fc_ff;
      nft_in       = nft_ff;
      team_in      = team_ff;
      node_in      = node_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;

      mem_we  = 1'b0;  mem_wa  = slot;     mem_wd  = '0;  mem_ra  = slot;
      team_we = 1'b0;  team_wa = team_ff;  team_wd = '0;  team_ra = team_ff;
      val_we  = 1'b0;  val_wa  = node_ff;  val_wd  = req_ff.element;
      val_ra  = head_ff;
      nxt_we  = 1'b0;  nxt_wa  = node_ff;  nxt_wd  = '0;  nxt_ra  = head_ff;
      free_we = 1'b0;  free_wa = CW'(fc_ff);  free_wd = head_ff;
      free_ra = CW'(fc_ff - 1'b1);
      ring_we = 1'b0;  ring_wa = TW'((TW + 1)'(oh_ff) + oc_ff);
      ring_wd = team_ff;  ring_ra = oh_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we     = clr_cnt_ff < CLRW'(ELEMENTS);
            mem_wa     = clr_cnt_ff[EW-1:0];
            team_we    = clr_cnt_ff < CLRW'(TEAMS);
            team_wa    = clr_cnt_ff[TW-1:0];
            free_we    = clr_cnt_ff < CLRW'(CAPACITY);
            free_wa    = clr_cnt_ff[CW-1:0];
            free_wd    = CW'(CAPACITY - 1) - clr_cnt_ff[CW-1:0];
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLRW'(CLR - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            rsp_in = '{element_out: '0, has_element: 1'b0, status: ST_OK};
            case (req_ff.opcode)
               OP_ASSIGN: begin
                  mem_we       = 1'b1;
                  mem_wd       = MW'({1'b0, assign_team} + 1'b1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               OP_ENQUEUE: begin
                  state_in = S_ENQ_LOOK;
               end
               OP_DEQUEUE: begin
                  if (oc_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_DEQ_TEAM;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_ENQ_LOOK: begin
            if (fc_ff == '0) begin
               rsp_in.status = ST_POOL_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (mem_rd == '0 && ids_out) begin
               rsp_in.status = ST_TEAMS_OUT;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               if (mem_rd == '0) begin
                  mem_we = 1'b1;
                  mem_wd = MW'(cand + 1'b1);
                  nft_in = NW'(cand);
               end
               // Pop a node and seed it as the new tail.
               fc_in   = fc_ff - 1'b1;
               node_in = free_rd;
               team_in = look_team;
               team_ra = look_team;
               val_we  = 1'b1;
               val_wa  = free_rd;
               nxt_we  = 1'b1;
               nxt_wa  = free_rd;
               state_in = S_ENQ_LINK;
            end
         end
         S_ENQ_LINK: begin
            team_we = 1'b1;
            if (rd_in_line) begin
               nxt_we  = 1'b1;
               nxt_wa  = rd_tail;
               nxt_wd  = node_ff;
               team_wd = {1'b1, rd_head, node_ff};
            end else begin
               team_wd = {1'b1, node_ff, node_ff};
               ring_we = 1'b1;
               oc_in   = oc_ff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DEQ_TEAM: begin
            team_in  = ring_rd;
            team_ra  = ring_rd;
            state_in = S_DEQ_NODE;
         end
         S_DEQ_NODE: begin
            head_in  = rd_head;
            tail_in  = rd_tail;
            val_ra   = rd_head;
            nxt_ra   = rd_head;
            state_in = S_DEQ_FINISH;
         end
         S_DEQ_FINISH: begin
            team_we = 1'b1;
            if (head_ff == tail_ff) begin
               // Last member leaves: drop the team from the line.
               team_wd = {1'b0, head_ff, tail_ff};
               oh_in   = oh_ff + 1'b1;
               oc_in   = oc_ff - 1'b1;
            end else begin
               team_wd = {1'b1, nxt_rd, tail_ff};
            end
            if (fc_ff < (CW + 1)'(CAPACITY)) begin
               free_we = 1'b1;
               fc_in   = fc_ff + 1'b1;
            end
            rsp_in = '{element_out: val_rd, has_element: 1'b1, status: ST_OK};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         nft_in = NW'(csr_wdata);
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== src/gftq_check.sv =====
`default_nettype none
`include "grouped_fifo_team_queue_assert.svh"
module gftq_check
   import gftq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   `GFTQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `GFTQ_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
   `GFTQ_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "double response")
   `GFTQ_ASSERT_NOW(a_elem_ok, clock, reset, rsp_valid && rsp_data.has_element, rsp_data.status == ST_OK, "element with error")
   `GFTQ_ASSERT_NOW(a_no_elem_zero, clock, reset, rsp_valid && !rsp_data.has_element, rsp_data.element_out == '0, "stray element")

endmodule

bind grouped_fifo_team_queue gftq_check u_gftq_check (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);
`default_nettype wire

// ===== test/grouped_fifo_team_queue_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module grouped_fifo_team_queue_test;
   import gftq_pkg::*;

   localparam int N_ELEM  = 65536;
   localparam int N_TEAMS = 1024;
   localparam int N_NODES = 4096;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic [PRED_W-1:0] csr_wdata;

   grouped_fifo_team_queue DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Predicted queue state
   int team_of[N_ELEM];        // 0 = no team, else team + 1
   bit in_line[N_TEAMS];
   int head_node[N_TEAMS];
   int tail_node[N_TEAMS];
   logic [ELEMENT_W-1:0] node_elem[N_NODES];
   int node_link[N_NODES];
   int free_list[N_NODES];
   int free_top;
   int line_ring[N_TEAMS];
   int line_head;
   int line_count;
   int next_fresh;

   req_type op_backlog[$];
   rsp_type due_responses[$];
   int mismatches;
   int gap_left;
   bit calm_tail;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_type apply_queue_op(req_type r);
      rsp_type o;
      int t;
      int node;
      int cand;
      bit go;
      o = '0;
      o.status = ST_OK;
      case (op_type'(r.opcode))
         OP_ASSIGN: begin
            team_of[r.element] = int'(r.team_id) + 1;
         end
         OP_ENQUEUE: begin
            go = 1'b1;
            t = 0;
            if (free_top == 0) begin
               o.status = ST_POOL_FULL;
               go = 1'b0;
            end else if (team_of[r.element] == 0) begin
               cand = next_fresh + 1;
               if (cand >= N_TEAMS) begin
                  o.status = ST_TEAMS_OUT;
                  go = 1'b0;
               end else begin
                  next_fresh = cand;
                  team_of[r.element] = cand + 1;
                  t = cand;
               end
            end else begin
               t = (team_of[r.element] - 1) % N_TEAMS;
            end
            if (go) begin
               free_top--;
               node = free_list[free_top];
               node_elem[node] = r.element;
               node_link[node] = 0;
               if (in_line[t]) begin
                  node_link[tail_node[t]] = node;
                  tail_node[t] = node;
               end else begin
                  head_node[t] = node;
                  tail_node[t] = node;
                  in_line[t] = 1'b1;
                  line_ring[(line_head + line_count) % N_TEAMS] = t;
                  line_count++;
               end
            end
         end
         OP_DEQUEUE: begin
            if (line_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               t = line_ring[line_head];
               node = head_node[t];
               o.element_out = node_elem[node];
               o.has_element = 1'b1;
               if (node == tail_node[t]) begin
                  in_line[t] = 1'b0;
                  line_head = (line_head + 1) % N_TEAMS;
                  line_count--;
               end else begin
                  head_node[t] = node_link[node];
               end
               if (free_top < N_NODES) begin
                  free_list[free_top] = node;
                  free_top++;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Driver: present backlog items, idling in random bursts
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else begin
         if (start && !busy)
            due_responses.push_back(apply_queue_op(req_data));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (op_backlog.size() > 0 && !(calm_tail && op_backlog.size() < 300)
                         && $urandom_range(0, 9) == 0) begin
               gap_left <= $urandom_range(0, 18);
               start <= 1'b0;
            end else if (op_backlog.size() > 0) begin
               req_data <= op_backlog.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic report(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Monitor: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_responses.size() == 0) begin
            $display("unexpected response at %0t", $realtime);
            mismatches++;
         end else begin
            want = due_responses.pop_front();
            if (rsp_data.element_out !== want.element_out)
               report("element_out", rsp_data.element_out, want.element_out);
            if (rsp_data.has_element !== want.has_element)
               report("has_element", rsp_data.has_element, want.has_element);
            if (rsp_data.status !== want.status)
               report("status", rsp_data.status, want.status);
         end
      end
   end

   task automatic push_op(op_type op, int elem, int team);
      req_type r;
      r.opcode = op;
      r.element = elem[ELEMENT_W-1:0];
      r.team_id = team[TEAM_ID_W-1:0];
      op_backlog.push_back(r);
   endtask

   task automatic drain;
      while (op_backlog.size() != 0 || start || due_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_team_count(int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[PRED_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      next_fresh = value;
   endtask

   task automatic queue_mix(int count);
      int k;
      int pick;
      int elem;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         elem = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 99) : $urandom_range(0, 65535);
         if (pick < 25)
            push_op(OP_ASSIGN, elem,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15));
         else if (pick < 70)
            push_op(OP_ENQUEUE, elem, $urandom_range(0, 1023));
         else if (pick < 98)
            push_op(OP_DEQUEUE, $urandom_range(0, 65535), $urandom_range(0, 1023));
         else
            push_op(OP_NOP, $urandom_range(0, 65535), $urandom_range(0, 1023));
      end
   endtask

   initial begin
      int k;
      int fill;
      for (k = 0; k < N_NODES; k++)
         free_list[k] = N_NODES - 1 - k;
      free_top = N_NODES;
      line_head = 0;
      line_count = 0;
      next_fresh = 0;
      mismatches = 0;
      calm_tail = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // hold off through the clearing pass
      while (busy) @(posedge clock);

      write_team_count(0);
      push_op(OP_DEQUEUE, 0, 0);
      push_op(OP_ASSIGN, 0, 0);
      push_op(OP_ASSIGN, 65535, 1023);
      push_op(OP_ENQUEUE, 0, 0);
      push_op(OP_ENQUEUE, 65535, 0);
      push_op(OP_ENQUEUE, 1234, 0);
      push_op(OP_ENQUEUE, 0, 1023);
      push_op(OP_ASSIGN, 0, 1023);
      push_op(OP_ENQUEUE, 0, 0);
      push_op(OP_NOP, 65535, 1023);
      push_op(OP_ENQUEUE, 4321, 0);
      for (k = 0; k < 7; k++)
         push_op(OP_DEQUEUE, 65535, 1023);
      drain();

      // one fresh id left, then exhaustion
      write_team_count(1022);
      push_op(OP_ENQUEUE, 777, 0);
      push_op(OP_ENQUEUE, 778, 0);
      queue_mix(300);
      drain();

      write_team_count(1024);
      push_op(OP_ENQUEUE, 900, 0);
      queue_mix(300);
      drain();

      // pile members onto a few teams, then empty the line
      write_team_count(500);
      push_op(OP_ASSIGN, 5, 3);
      fill = 250;
      for (k = 0; k < fill; k++)
         push_op(OP_ENQUEUE, ($urandom_range(0, 1)) ? 5 : $urandom_range(0, 40), 0);
      for (k = 0; k < fill + 20; k++)
         push_op(OP_DEQUEUE, 0, 0);
      drain();

      write_team_count($urandom_range(0, 1023));
      calm_tail = 1'b1;
      queue_mix(900);
      drain();

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
